// File: hw/rtl/fws_pkg.sv
// shared types, constants and fixed-point helpers of the foliage wind sway unit
package fws_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] rest_rot_x;
    logic signed [31:0] rest_rot_z;
    logic [31:0]        time_now;
    logic               profile_valid;
    logic signed [31:0] speed_scale;
    logic signed [31:0] strength_scale;
    logic signed [31:0] turbulence_scale;
    logic signed [31:0] bend_limit_scale;
    logic signed [31:0] phase_offset;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_rot_x;
    logic signed [31:0] new_rot_z;
    logic               changed;
  } out_t;

  typedef enum logic [2:0] {
    CFG_ENABLED      = 3'd0,
    CFG_DIR_X        = 3'd1,
    CFG_DIR_Z        = 3'd2,
    CFG_WIND_SPEED   = 3'd3,
    CFG_WIND_STRENGTH = 3'd4,
    CFG_TURBULENCE   = 3'd5,
    CFG_WAVE_SIZE    = 3'd6,
    CFG_USE_PROFILES = 3'd7
  } cfg_idx_t;

  localparam logic signed [31:0] K_LEAN          = 32'sd39322;
  localparam logic signed [31:0] K_SWAY          = 32'sd26214;
  localparam logic signed [31:0] K_P2            = 32'sd150733;
  localparam logic signed [31:0] K_T2            = 32'sd111411;
  localparam logic signed [31:0] K_P3            = 32'sd268698;
  localparam logic signed [31:0] K_T3            = 32'sd190054;
  localparam logic signed [16:0] K_W2            = 17'sd22938;
  localparam logic signed [16:0] K_W3            = 17'sd9830;
  localparam logic signed [31:0] BEND_LIMIT_Q    = 32'sd1638400;
  localparam logic signed [31:0] WAVE_MIN_Q      = 32'sd6553;
  localparam logic signed [31:0] WAVE_FALLBACK_Q = 32'sd3276800;
  localparam logic signed [6:0]  LIMIT_MUL       = 7'sd25;
  localparam logic [29:0]        INV_TWO_PI_Q32  = 30'd683565276;
  localparam logic [16:0]        SIN_A           = 17'd102944;
  localparam logic [15:0]        SIN_B           = 16'd42047;
  localparam logic [12:0]        SIN_C           = 13'd4640;
  localparam logic [16:0]        SIN_MAX         = 17'd65536;
  localparam logic [18:0]        RECIP3_Q20      = 19'd349526;

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > $signed(72'h7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -$signed(72'h8000_0000)) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // q16.16 product, floored and clamped
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] sh;
    p  = a * b;
    sh = p >>> 16;
    return sat32(72'(sh));
  endfunction

endpackage

// File: hw/rtl/fws_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
module fws_div #(
  parameter int DW = 51,
  parameter int VW = 31,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [DW-1:0] quotient,
  output logic [SW-1:0] side_out
);

  logic          vld  [0:DW];
  logic [DW-1:0] numq [0:DW];
  logic [VW-1:0] rem  [0:DW];
  logic [VW-1:0] den  [0:DW];
  logic [SW-1:0] side [0:DW];
  logic [VW:0]   trial [0:DW-1];
  logic [VW:0]   diff  [0:DW-1];
  logic          take  [0:DW-1];

  always_comb begin
    for (int i = 0; i < DW; i++) begin
      trial[i] = {rem[i], numq[i][DW-1]};
      diff[i]  = trial[i] - {1'b0, den[i]};
      take[i]  = (trial[i] >= {1'b0, den[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= DW; i++) vld[i] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_valid;
      for (int i = 0; i < DW; i++) vld[i+1] <= vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      numq[0] <= dividend;
      rem[0]  <= '0;
      den[0]  <= divisor;
      side[0] <= side_in;
      for (int i = 0; i < DW; i++) begin
        rem[i+1]  <= take[i] ? diff[i][VW-1:0] : trial[i][VW-1:0];
        numq[i+1] <= {numq[i][DW-2:0], take[i]};
        den[i+1]  <= den[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[DW];
  assign quotient  = numq[DW];
  assign side_out  = side[DW];

endmodule

// File: hw/rtl/fws_isqrt.sv
// pipelined floor square root of a 64-bit value, one root bit per stage
module fws_isqrt #(
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_valid,
  input  logic [63:0]   radicand,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [31:0]   root,
  output logic [SW-1:0] side_out
);

  localparam int NS = 32;

  logic          vld  [0:NS];
  logic [63:0]   rad  [0:NS];
  logic [33:0]   rem  [0:NS];
  logic [31:0]   rt   [0:NS];
  logic [SW-1:0] side [0:NS];
  logic [35:0]   cur  [0:NS-1];
  logic [35:0]   trl  [0:NS-1];
  logic [35:0]   diff [0:NS-1];
  logic          take [0:NS-1];

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      cur[i]  = {rem[i], rad[i][63:62]};
      trl[i]  = {2'b00, rt[i], 2'b01};
      diff[i] = cur[i] - trl[i];
      take[i] = (cur[i] >= trl[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NS; i++) vld[i] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_valid;
      for (int i = 0; i < NS; i++) vld[i+1] <= vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rad[0]  <= radicand;
      rem[0]  <= '0;
      rt[0]   <= '0;
      side[0] <= side_in;
      for (int i = 0; i < NS; i++) begin
        rem[i+1]  <= take[i] ? diff[i][33:0] : cur[i][33:0];
        rt[i+1]   <= {rt[i][30:0], take[i]};
        rad[i+1]  <= {rad[i][61:0], 2'b00};
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[NS];
  assign root      = rt[NS];
  assign side_out  = side[NS];

endmodule

// File: hw/rtl/fws_sin.sv
// three-lane pipelined sine on a 16-bit turn, quarter-wave polynomial
module fws_sin import fws_pkg::*; #(
  parameter int SW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_valid,
  input  logic signed [32:0] arg [3],
  input  logic [SW-1:0]      side_in,
  output logic               out_valid,
  output logic signed [17:0] sine [3],
  output logic [SW-1:0]      side_out
);

  logic [4:0]    vld;
  logic [SW-1:0] sd [0:4];

  logic [15:0] p1  [3];
  logic [1:0]  q2  [3];
  logic [14:0] x2  [3];
  logic [14:0] xx2 [3];
  logic [1:0]  q3  [3];
  logic [14:0] x3  [3];
  logic [14:0] xx3 [3];
  logic [15:0] tb3 [3];
  logic [1:0]  q4  [3];
  logic [14:0] x4  [3];
  logic [16:0] ta4 [3];

  logic signed [63:0] prod [3];
  logic [14:0]        xs   [3];
  logic [14:0]        xf   [3];
  logic [29:0]        sq   [3];
  logic [27:0]        m3   [3];
  logic [30:0]        m4   [3];
  logic [31:0]        m5   [3];
  logic [16:0]        rc   [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      prod[l] = arg[l] * $signed({1'b0, INV_TWO_PI_Q32});
      xs[l]   = {1'b0, p1[l][13:0]};
      xf[l]   = p1[l][14] ? (15'h4000 - xs[l]) : xs[l];
      sq[l]   = 30'(xf[l]) * 30'(xf[l]);
      m3[l]   = 28'(SIN_C) * 28'(xx2[l]);
      m4[l]   = 31'(tb3[l]) * 31'(xx3[l]);
      m5[l]   = 32'(ta4[l]) * 32'(x4[l]);
      rc[l]   = (m5[l][31:14] > 18'(SIN_MAX)) ? SIN_MAX : m5[l][30:14];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sd[0] <= side_in;
      for (int s = 0; s < 4; s++) sd[s+1] <= sd[s];
      for (int l = 0; l < 3; l++) begin
        // turn angle
        p1[l]   <= prod[l][47:32];
        // fold into the first quarter, square
        q2[l]   <= p1[l][15:14];
        x2[l]   <= xf[l];
        xx2[l]  <= sq[l][28:14];
        // horner steps
        q3[l]   <= q2[l];
        x3[l]   <= x2[l];
        xx3[l]  <= xx2[l];
        tb3[l]  <= SIN_B - 16'(m3[l][27:14]);
        q4[l]   <= q3[l];
        x4[l]   <= x3[l];
        ta4[l]  <= SIN_A - m4[l][30:14];
        sine[l] <= q4[l][1] ? -$signed({1'b0, rc[l]}) : $signed({1'b0, rc[l]});
      end
    end
  end

  assign out_valid = vld[4];
  assign side_out  = sd[4];

endmodule

// File: hw/rtl/foliage_wind_sway_unit.sv
// top level of the foliage wind sway unit: config registers and the sway pipeline
//
// one plant instance per input beat on in_data, one result beat on out_data.
// both channels use valid and stall; a beat moves at a clock edge with valid
// high and stall low. configuration goes through cfg_we / cfg_index /
// cfg_data; the user must write it only while no beat is in flight, since
// the block does not enforce this. a beat reaches the output register through
// the position / wave size divider (52 stages), three sine lanes (5 stages),
// the bend magnitude square root (33 stages) and the bend limit dividers
// (64 stages), plus single-stage multiply steps. every stage is a register
// with a valid bit. throughput: one beat per cycle while no result is held.
// when out_stall holds a waiting result the whole pipeline freezes and
// in_stall rises in the same cycle, so nothing is dropped or repeated.
// reset (rst, synchronous) clears all valid bits and loads the register
// defaults: wind off, direction +x, speed 1.0, strength 0, turbulence 1.5,
// wave size 50, profiles off. no clearing pass is needed.
module foliage_wind_sway_unit import fws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // sideband groups carried past the long units
  typedef struct packed {
    logic               act;
    logic               neg;
    logic signed [31:0] poff;
    logic signed [31:0] tp;
    logic signed [31:0] lean;
    logic signed [31:0] sway;
    logic signed [31:0] turb;
    logic signed [31:0] limit;
    logic signed [31:0] rx;
    logic signed [31:0] rz;
  } side_a_t;

  typedef struct packed {
    logic               act;
    logic signed [31:0] lean;
    logic signed [31:0] sway;
    logic signed [31:0] limit;
    logic signed [31:0] rx;
    logic signed [31:0] rz;
  } side_b_t;

  typedef struct packed {
    logic               act;
    logic signed [31:0] bx;
    logic signed [31:0] bz;
    logic signed [31:0] limit;
    logic signed [31:0] rx;
    logic signed [31:0] rz;
  } side_c_t;

  typedef struct packed {
    logic               act;
    logic               over;
    logic               neg;
    logic signed [31:0] bx;
    logic signed [31:0] rx;
    logic signed [31:0] rz;
  } side_d_t;

  typedef struct packed {
    logic               neg;
    logic signed [31:0] bz;
  } side_e_t;

  // configuration registers
  logic               enabled;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_z;
  logic signed [31:0] wind_speed;
  logic signed [31:0] wind_strength;
  logic signed [31:0] turbulence;
  logic signed [31:0] wave_size;
  logic               use_profiles;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled       <= 1'b0;
      dir_x         <= 16'sd16384;
      dir_z         <= 16'sd0;
      wind_speed    <= 32'sd65536;
      wind_strength <= 32'sd0;
      turbulence    <= 32'sd98304;
      wave_size     <= 32'sd3276800;
      use_profiles  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLED:       enabled       <= cfg_data[0];
        CFG_DIR_X:         dir_x         <= cfg_data[15:0];
        CFG_DIR_Z:         dir_z         <= cfg_data[15:0];
        CFG_WIND_SPEED:    wind_speed    <= cfg_data;
        CFG_WIND_STRENGTH: wind_strength <= cfg_data;
        CFG_TURBULENCE:    turbulence    <= cfg_data;
        CFG_WAVE_SIZE:     wave_size     <= cfg_data;
        CFG_USE_PROFILES:  use_profiles  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // global advance: freeze everything while a finished result is held
  logic ce;
  assign ce       = !(out_valid && out_stall);
  assign in_stall = !ce;

  // input register
  logic v0;
  in_t  d0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (ce) v0 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) d0 <= in_data;
  end

  // stage 1: profile scaling, direction dot products, wave size select
  logic               prof;
  logic signed [36:0] lim_prod;
  logic signed [47:0] px_c, pz_c;

  logic               v1, act1;
  logic signed [31:0] spd1, str1, trb1, lim1, poff1, rx1, rz1;
  logic signed [47:0] px1, pz1;
  logic [30:0]        wave1;
  logic [31:0]        time1;

  always_comb begin
    prof     = d0.profile_valid & use_profiles;
    lim_prod = d0.bend_limit_scale * LIMIT_MUL;
    px_c     = d0.pos_x * dir_x;
    pz_c     = d0.pos_z * dir_z;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (ce) v1 <= v0;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      act1  <= enabled && (dir_x != 16'sd0 || dir_z != 16'sd0);
      spd1  <= prof ? mulq(wind_speed, d0.speed_scale) : wind_speed;
      str1  <= prof ? mulq(wind_strength, d0.strength_scale) : wind_strength;
      trb1  <= prof ? mulq(turbulence, d0.turbulence_scale) : turbulence;
      lim1  <= prof ? sat32(72'(lim_prod)) : BEND_LIMIT_Q;
      poff1 <= prof ? d0.phase_offset : 32'sd0;
      px1   <= px_c;
      pz1   <= pz_c;
      // small or negative wave sizes fall back to 50
      wave1 <= (wave_size > WAVE_MIN_Q) ? wave_size[30:0] : WAVE_FALLBACK_Q[30:0];
      time1 <= d0.time_now;
      rx1   <= d0.rest_rot_x;
      rz1   <= d0.rest_rot_z;
    end
  end

  // stage 2: spatial dividend, time phase, lean and sway amplitudes
  logic signed [48:0] dot;
  logic signed [50:0] dot4;
  logic               dneg;
  logic [50:0]        dmag;
  logic signed [64:0] tprod;
  logic signed [64:0] tsh;
  side_a_t            sa_in, sa_out;
  logic               vq;
  logic [50:0]        q51;

  always_comb begin
    dot  = 49'(px1) + 49'(pz1);
    dot4 = {dot, 2'b00};
    dneg = dot4[50];
    dmag = dneg ? (~dot4 + 51'd1) : dot4;
    tprod = $signed({1'b0, time1}) * spd1;
    tsh   = tprod >>> 16;
    sa_in.act   = act1;
    sa_in.neg   = dneg;
    sa_in.poff  = poff1;
    sa_in.tp    = sat32(72'(tsh));
    sa_in.lean  = mulq(str1, K_LEAN);
    sa_in.sway  = mulq(str1, K_SWAY);
    sa_in.turb  = trb1;
    sa_in.limit = lim1;
    sa_in.rx    = rx1;
    sa_in.rz    = rz1;
  end

  fws_div #(
    .DW(51),
    .VW(31),
    .SW($bits(side_a_t))
  ) u_wave_div (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (v1),
    .dividend (dmag),
    .divisor  (wave1),
    .side_in  (sa_in),
    .out_valid(vq),
    .quotient (q51),
    .side_out (sa_out)
  );

  // stage 3: signed spatial phase plus profile offset
  logic signed [52:0] qsig;
  logic signed [71:0] ppsum;
  logic               v3;
  logic signed [31:0] pp3;
  side_a_t            sd3;

  always_comb begin
    qsig  = sa_out.neg ? -$signed({2'b00, q51}) : $signed({2'b00, q51});
    ppsum = 72'(qsig) + 72'(sa_out.poff);
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (ce) v3 <= vq;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pp3 <= sat32(ppsum);
      sd3 <= sa_out;
    end
  end

  // stage 4: harmonic arguments, first multiply layer
  logic               v4;
  logic signed [32:0] a1_4, a2_4;
  logic signed [31:0] p3_4, t3_4;
  side_a_t            sd4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (ce) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a1_4 <= 33'(pp3) + 33'(sd3.tp);
      a2_4 <= 33'(mulq(pp3, K_P2)) + 33'(mulq(sd3.tp, K_T2));
      p3_4 <= mulq(pp3, K_P3);
      t3_4 <= mulq(sd3.tp, K_T3);
      sd4  <= sd3;
    end
  end

  // stage 5: third harmonic scaled by turbulence
  logic               v5;
  logic signed [32:0] arg5 [3];
  side_b_t            sb5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (ce) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      arg5[0]   <= a1_4;
      arg5[1]   <= a2_4;
      arg5[2]   <= 33'(p3_4) + 33'(mulq(t3_4, sd4.turb));
      sb5.act   <= sd4.act;
      sb5.lean  <= sd4.lean;
      sb5.sway  <= sd4.sway;
      sb5.limit <= sd4.limit;
      sb5.rx    <= sd4.rx;
      sb5.rz    <= sd4.rz;
    end
  end

  logic               vs;
  logic signed [17:0] sn [3];
  side_b_t            sb_out;

  fws_sin #(
    .SW($bits(side_b_t))
  ) u_sin (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (v5),
    .arg      (arg5),
    .side_in  (sb5),
    .out_valid(vs),
    .sine     (sn),
    .side_out (sb_out)
  );

  // stage 6: harmonic weights
  logic signed [34:0] w2, w3;
  logic               v6;
  logic signed [17:0] s1_6;
  logic signed [18:0] s2_6, s3_6;
  side_b_t            sd6;

  always_comb begin
    w2 = sn[1] * K_W2;
    w3 = sn[2] * K_W3;
  end

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (ce) v6 <= vs;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_6 <= sn[0];
      s2_6 <= w2[34:16];
      s3_6 <= w3[34:16];
      sd6  <= sb_out;
    end
  end

  // stage 7: oscillation = 2/3 of the sum, truncated toward zero
  logic signed [20:0] ssum;
  logic signed [21:0] sdbl;
  logic               oneg;
  logic [21:0]        oabs;
  logic [39:0]        oprod;
  logic [18:0]        oq;
  logic               v7;
  logic signed [19:0] osc7;
  side_b_t            sd7;

  always_comb begin
    ssum  = 21'(s1_6) + 21'(s2_6) + 21'(s3_6);
    sdbl  = {ssum, 1'b0};
    oneg  = sdbl[21];
    oabs  = oneg ? (~sdbl + 22'd1) : sdbl;
    oprod = 40'(oabs[18:0]) * 40'(RECIP3_Q20);
    oq    = oprod[38:20];
  end

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (ce) v7 <= v6;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      osc7 <= oneg ? -$signed({1'b0, oq}) : $signed({1'b0, oq});
      sd7  <= sd6;
    end
  end

  // stage 8: amplitude = lean + osc * sway
  logic               v8;
  logic signed [32:0] amp8;
  side_b_t            sd8;

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (ce) v8 <= v7;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      amp8 <= 33'(sd7.lean) + 33'(mulq(32'(osc7), sd7.sway));
      sd8  <= sd7;
    end
  end

  // stage 9: bend across the wind direction
  logic signed [48:0] bxp, bzp;
  logic signed [48:0] bxs, bzs;
  logic               v9;
  logic signed [31:0] bx9, bz9;
  side_b_t            sd9;

  always_comb begin
    bxp = dir_z * amp8;
    bzp = dir_x * amp8;
    bxs = bxp >>> 14;
    bzs = bzp >>> 14;
  end

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (ce) v9 <= v8;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      bx9 <= sat32(72'(bxs));
      bz9 <= sat32(-(72'(bzs)));
      sd9 <= sd8;
    end
  end

  // stage 10: squares for the bend magnitude
  logic               v10;
  logic signed [63:0] sqx10, sqz10;
  logic signed [31:0] bx10, bz10;
  side_b_t            sd10;

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (ce) v10 <= v9;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sqx10 <= bx9 * bx9;
      sqz10 <= bz9 * bz9;
      bx10  <= bx9;
      bz10  <= bz9;
      sd10  <= sd9;
    end
  end

  // magnitude square root
  logic [63:0] rad;
  side_c_t     sc_in, sc_out;
  logic        vm;
  logic [31:0] mag;

  always_comb begin
    rad         = sqx10 + sqz10;
    sc_in.act   = sd10.act;
    sc_in.bx    = bx10;
    sc_in.bz    = bz10;
    sc_in.limit = sd10.limit;
    sc_in.rx    = sd10.rx;
    sc_in.rz    = sd10.rz;
  end

  fws_isqrt #(
    .SW($bits(side_c_t))
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (v10),
    .radicand (rad),
    .side_in  (sc_in),
    .out_valid(vm),
    .root     (mag),
    .side_out (sc_out)
  );

  // stage 12: limit test and scaled bend numerators
  logic               v12, over12;
  logic signed [63:0] pbx12, pbz12;
  logic [31:0]        mag12;
  side_c_t            sd12;

  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (ce) v12 <= vm;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      // a negative limit catches every nonzero bend
      over12 <= ($signed({2'b00, mag}) > 34'(sc_out.limit)) && (mag != 32'd0);
      pbx12  <= sc_out.bx * sc_out.limit;
      pbz12  <= sc_out.bz * sc_out.limit;
      mag12  <= mag;
      sd12   <= sc_out;
    end
  end

  // bend limit dividers
  logic        nxs, nzs;
  logic [63:0] abx, abz;
  side_d_t     sdd_in, sdd_out;
  side_e_t     sde_in, sde_out;
  logic        vdx, vdz;
  logic [62:0] qx, qz;

  always_comb begin
    nxs = pbx12[63];
    nzs = pbz12[63];
    abx = nxs ? (~pbx12 + 64'd1) : pbx12;
    abz = nzs ? (~pbz12 + 64'd1) : pbz12;
    sdd_in.act  = sd12.act;
    sdd_in.over = over12;
    sdd_in.neg  = nxs;
    sdd_in.bx   = sd12.bx;
    sdd_in.rx   = sd12.rx;
    sdd_in.rz   = sd12.rz;
    sde_in.neg  = nzs;
    sde_in.bz   = sd12.bz;
  end

  fws_div #(
    .DW(63),
    .VW(32),
    .SW($bits(side_d_t))
  ) u_limx_div (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (v12),
    .dividend (abx[62:0]),
    .divisor  (mag12),
    .side_in  (sdd_in),
    .out_valid(vdx),
    .quotient (qx),
    .side_out (sdd_out)
  );

  fws_div #(
    .DW(63),
    .VW(32),
    .SW($bits(side_e_t))
  ) u_limz_div (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (v12),
    .dividend (abz[62:0]),
    .divisor  (mag12),
    .side_in  (sde_in),
    .out_valid(vdz),
    .quotient (qz),
    .side_out (sde_out)
  );

  // output stage: final bend, add to rest rotation, wind-off bypass
  logic signed [63:0] fx, fz;
  out_t               res;

  always_comb begin
    if (sdd_out.over) begin
      fx = sdd_out.neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      fz = sde_out.neg ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
    end else begin
      fx = 64'(sdd_out.bx);
      fz = 64'(sde_out.bz);
    end
    if (sdd_out.act) begin
      res.new_rot_x = sat32(72'(sdd_out.rx) + 72'(fx));
      res.new_rot_z = sat32(72'(sdd_out.rz) + 72'(fz));
      res.changed   = 1'b1;
    end else begin
      res.new_rot_x = sdd_out.rx;
      res.new_rot_z = sdd_out.rz;
      res.changed   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ce) out_valid <= vdx & vdz;
  end

  always_ff @(posedge clk) begin
    if (ce) out_data <= res;
  end

endmodule
